### rtl/best_fit_slice_allocator_macros.svh
// Assertion macros for the best-fit slice allocator checker.
// Depends on signals named clock and reset in the using scope.
`ifndef BEST_FIT_SLICE_ALLOCATOR_MACROS_SVH
`define BEST_FIT_SLICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, off during reset
`define BFSA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bfsa check failed");

// Next-cycle implication, off during reset
`define BFSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bfsa check failed");

// Next-cycle implication, live during reset
`define BFSA_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("bfsa check failed");

`endif

### rtl/bfsa_pkg.sv
// Package for the best-fit slice allocator: sizes, codes and shared structs.
// No dependencies.
package bfsa_pkg;

   localparam int unsigned POOL_BYTES      = 16777216;
   localparam int unsigned MAX_SLICE_BYTES = 1048576;
   localparam int unsigned TABLE_SLOTS     = 64;
   localparam int unsigned ALIGN_BYTES     = 8;

   localparam int unsigned SLOT_W   = $clog2(TABLE_SLOTS);
   localparam int unsigned START_W  = 24;
   localparam int unsigned LEN_W    = 21;
   localparam int unsigned GAP_W    = 25;
   localparam int unsigned REQ_W    = 25;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 48;

   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [START_W-1:0] start_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [GAP_W-1:0]   gap_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_SIZE     = 3'd1,
      ST_NOFIT    = 3'd2,
      ST_NOTALLOC = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef struct packed {
      logic      valid;
      slot_type  slot;
      start_type start;
      len_type   length;
      gap_type   gap;
   } entry_type;

   typedef struct packed {
      logic      wr_full;
      logic      wr_gap;
      logic      clr;
      slot_type  slot;
      start_type start;
      len_type   length;
      gap_type   gap;
   } tbl_wr_type;

   typedef struct packed {
      logic      best_found;
      logic      best_root;
      slot_type  best_slot;
      gap_type   best_gap;
      gap_type   best_pos;
      logic      free_found;
      slot_type  free_slot;
      logic      hit_found;
      slot_type  hit_slot;
      len_type   hit_len;
      gap_type   hit_gap;
      logic      pred_found;
      slot_type  pred_slot;
      start_type pred_start;
      gap_type   pred_gap;
   } scan_res_type;

endpackage

### rtl/bfsa_tbl.sv
// Slice table: valid flags in flops, start/length/gap in memories, registered read.
// Depends on bfsa_pkg.
module bfsa_tbl import bfsa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  slot_type   rd_slot,
   input  tbl_wr_type wr,
   output entry_type  rd_entry
);

   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [TABLE_SLOTS-1:0] valid_in;
   start_type start_mem [TABLE_SLOTS];
   len_type   len_mem   [TABLE_SLOTS];
   gap_type   gap_mem   [TABLE_SLOTS];
   entry_type rd_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.wr_full) begin
         valid_in[wr.slot] = 1'b1;
      end
      if (wr.clr) begin
         valid_in[wr.slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.wr_full) begin
         start_mem[wr.slot] <= wr.start;
         len_mem[wr.slot]   <= wr.length;
      end
      if (wr.wr_full || wr.wr_gap) begin
         gap_mem[wr.slot] <= wr.gap;
      end
      rd_ff.valid  <= valid_ff[rd_slot];
      rd_ff.slot   <= rd_slot;
      rd_ff.start  <= start_mem[rd_slot];
      rd_ff.length <= len_mem[rd_slot];
      rd_ff.gap    <= gap_mem[rd_slot];
   end

   assign rd_entry = rd_ff;

endmodule

### rtl/bfsa_scan.sv
// Shared compare unit: folds one table entry per cycle into the best-fit,
// free-slot, hit and predecessor trackers. Depends on bfsa_pkg.
module bfsa_scan import bfsa_pkg::*; (
   input  logic         clock,
   input  logic         clear,
   input  logic         eval,
   input  len_type      size,
   input  start_type    offset,
   input  gap_type      root_gap,
   input  entry_type    entry,
   output scan_res_type res
);

   scan_res_type res_ff;
   scan_res_type res_in;
   gap_type      pos;
   logic         fits;
   logic         better;

   always_comb begin
      pos    = {1'b0, entry.start} + GAP_W'(entry.length);
      fits   = entry.gap >= GAP_W'(size);
      better = !res_ff.best_found || (entry.gap < res_ff.best_gap) ||
               ((entry.gap == res_ff.best_gap) && (pos < res_ff.best_pos));
      res_in = res_ff;
      if (clear) begin
         res_in = '0;
         if (root_gap >= GAP_W'(size)) begin
            res_in.best_found = 1'b1;
            res_in.best_root  = 1'b1;
            res_in.best_gap   = root_gap;
         end
      end else if (eval) begin
         if (!entry.valid) begin
            if (!res_ff.free_found) begin
               res_in.free_found = 1'b1;
               res_in.free_slot  = entry.slot;
            end
         end else begin
            if (fits && better) begin
               res_in.best_found = 1'b1;
               res_in.best_root  = 1'b0;
               res_in.best_slot  = entry.slot;
               res_in.best_gap   = entry.gap;
               res_in.best_pos   = pos;
            end
            if (!res_ff.hit_found && (entry.start == offset)) begin
               res_in.hit_found = 1'b1;
               res_in.hit_slot  = entry.slot;
               res_in.hit_len   = entry.length;
               res_in.hit_gap   = entry.gap;
            end
            if ((entry.start < offset) &&
                (!res_ff.pred_found || (entry.start > res_ff.pred_start))) begin
               res_in.pred_found = 1'b1;
               res_in.pred_slot  = entry.slot;
               res_in.pred_start = entry.start;
               res_in.pred_gap   = entry.gap;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

### rtl/best_fit_slice_allocator.sv
// Channel   Dir  tdata (low bit up)                          tuser
// req_*     in   req_bytes[24:0], slice_offset[48:25], pad    func
// rsp_*     out  alloc_offset[23:0], granted_bytes[44:24], pad status[2:0]
//
// An allocate or free runs from accept to result as one table read per slot
// (64) through the shared compare unit, then drain, decide, two update states
// and the reply. A request that fails after the scan skips the update states.
// An allocate with a bad size goes from accept straight to the reply.
// Reset clears the valid flags and restores the root gap.
// A stalled result holds in the output register; the next request is taken
// meanwhile, and its reply waits for that register to empty.
module best_fit_slice_allocator import bfsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // req_bytes, slice_offset
   input  logic                  req_tuser,  // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // alloc_offset, granted_bytes
   output logic [STATUS_W-1:0]   rsp_tuser   // status
);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_UPD1, S_UPD2, S_REPLY
   } state_type;

   state_type    state_ff, state_in;
   slot_type     cnt_ff, cnt_in;
   logic         eval_ff, eval_in;
   func_type     func_ff, func_in;
   len_type      size_ff, size_in;
   start_type    off_ff, off_in;
   gap_type      root_gap_ff, root_gap_in;
   status_type   res_status_ff, res_status_in;
   start_type    res_off_ff, res_off_in;
   len_type      res_grant_ff, res_grant_in;
   logic         rsp_valid_ff, rsp_valid_in;
   status_type   rsp_status_ff, rsp_status_in;
   start_type    rsp_off_ff, rsp_off_in;
   len_type      rsp_grant_ff, rsp_grant_in;

   logic         accept;
   logic         scan_clear;
   logic [REQ_W:0] rounded;
   logic         size_bad;
   tbl_wr_type   wr;
   entry_type    rd_entry;
   scan_res_type res;

   bfsa_tbl u_tbl (
      .clock    (clock),
      .reset    (reset),
      .rd_slot  (cnt_ff),
      .wr       (wr),
      .rd_entry (rd_entry)
   );

   bfsa_scan u_scan (
      .clock    (clock),
      .clear    (scan_clear),
      .eval     (eval_ff),
      .size     (size_ff),
      .offset   (off_ff),
      .root_gap (root_gap_ff),
      .entry    (rd_entry),
      .res      (res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign scan_clear = (state_ff == S_IDLE) || ((state_ff == S_SCAN) && (cnt_ff == '0));
   assign rounded    = ({1'b0, req_tdata[REQ_W-1:0]} + (REQ_W+1)'(ALIGN_BYTES - 1)) &
                       ~(REQ_W+1)'(ALIGN_BYTES - 1);
   assign size_bad   = (rounded == '0) || (rounded > (REQ_W+1)'(MAX_SLICE_BYTES));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      eval_in       = (state_ff == S_SCAN);
      func_in       = func_ff;
      size_in       = size_ff;
      off_in        = off_ff;
      root_gap_in   = root_gap_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      res_grant_in  = res_grant_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_grant_in  = rsp_grant_ff;
      wr            = '0;

      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               func_in      = func_type'(req_tuser);
               size_in      = rounded[LEN_W-1:0];
               off_in       = req_tdata[REQ_W +: START_W];
               res_status_in = ST_OK;
               res_off_in   = '0;
               res_grant_in = '0;
               if ((func_type'(req_tuser) == FUNC_ALLOC) && size_bad) begin
                  res_status_in = ST_SIZE;
                  state_in      = S_REPLY;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == slot_type'(TABLE_SLOTS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_UPD1;
            if (func_ff == FUNC_ALLOC) begin
               if (!res.best_found) begin
                  res_status_in = ST_NOFIT;
                  state_in      = S_REPLY;
               end else if (!res.free_found) begin
                  res_status_in = ST_FULL;
                  state_in      = S_REPLY;
               end else begin
                  res_off_in   = res.best_pos[START_W-1:0];
                  res_grant_in = size_ff;
               end
            end else begin
               if (!res.hit_found) begin
                  res_status_in = ST_NOTALLOC;
                  state_in      = S_REPLY;
               end else begin
                  res_grant_in = res.hit_len;
               end
            end
         end
         S_UPD1: begin
            state_in = S_UPD2;
            if (func_ff == FUNC_ALLOC) begin
               wr.wr_full = 1'b1;
               wr.slot    = res.free_slot;
               wr.start   = res.best_pos[START_W-1:0];
               wr.length  = size_ff;
               wr.gap     = res.best_gap - GAP_W'(size_ff);
            end else begin
               wr.clr  = 1'b1;
               wr.slot = res.hit_slot;
            end
         end
         S_UPD2: begin
            state_in = S_REPLY;
            if (func_ff == FUNC_ALLOC) begin
               if (res.best_root) begin
                  root_gap_in = '0;
               end else begin
                  wr.wr_gap = 1'b1;
                  wr.slot   = res.best_slot;
                  wr.gap    = '0;
               end
            end else begin
               if (res.pred_found) begin
                  wr.wr_gap = 1'b1;
                  wr.slot   = res.pred_slot;
                  wr.gap    = res.pred_gap + GAP_W'(res.hit_len) + res.hit_gap;
               end else begin
                  root_gap_in = root_gap_ff + GAP_W'(res.hit_len) + res.hit_gap;
               end
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_off_in    = res_off_ff;
               rsp_grant_in  = res_grant_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         eval_ff      <= 1'b0;
         root_gap_ff  <= GAP_W'(POOL_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         eval_ff      <= eval_in;
         root_gap_ff  <= root_gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      size_ff       <= size_in;
      off_ff        <= off_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      res_grant_ff  <= res_grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_grant_ff  <= rsp_grant_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_grant_ff, rsp_off_ff});

endmodule

### rtl/bfsa_checker.sv
// Port-level checks for the best-fit slice allocator, bound to the top level.
// Depends on bfsa_pkg and best_fit_slice_allocator_macros.svh.
`include "best_fit_slice_allocator_macros.svh"

module bfsa_checker import bfsa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,  // req_bytes, slice_offset
   input logic                  req_tuser,  // func
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,  // alloc_offset, granted_bytes
   input logic [STATUS_W-1:0]   rsp_tuser   // status
);

   logic in_xact;
   logic rsp_ok;
   logic rsp_err;

   assign in_xact = req_tvalid && req_tready;
   assign rsp_ok  = rsp_tvalid && (rsp_tuser == ST_OK);
   assign rsp_err = rsp_tvalid && (rsp_tuser != ST_OK);

   `BFSA_ASSERT_ALWAYS(a_reset_idle, reset, req_tready && !rsp_tvalid)
   `BFSA_ASSERT_NEXT(a_busy_after_req, in_xact, !req_tready)
   `BFSA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `BFSA_ASSERT_NOW(a_ok_has_size, rsp_ok, rsp_tdata[44:24] != '0)
   `BFSA_ASSERT_NOW(a_err_zero, rsp_err, rsp_tdata == '0 && !req_tdata[REQ_DATA_W-1])

endmodule

bind best_fit_slice_allocator bfsa_checker u_bfsa_checker (.*);

### dv/testbench.sv
// Self-checking testbench for best_fit_slice_allocator: predicts each reply from its own
// slice table and compares status, offset and byte count of every rsp transaction.
// Depends on bfsa_pkg and the best_fit_slice_allocator RTL.
module testbench;
   import bfsa_pkg::*;

   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 600000;

   typedef struct packed {
      status_type status;
      start_type  offset;
      len_type    granted;
   } reply_type;

   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_PERIODIC
   } ready_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   logic      slot_used  [TABLE_SLOTS];
   start_type slot_start [TABLE_SLOTS];
   len_type   slot_len   [TABLE_SLOTS];
   gap_type   slot_gap   [TABLE_SLOTS];
   gap_type   root_free;

   reply_type pending_replies[$];
   int        error_count;
   int        cycle_count;
   int        burst_left;
   logic      hold_request;

   best_fit_slice_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d replies outstanding", $time, pending_replies.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic reply_type alloc_slice(input logic [REQ_W-1:0] bytes);
      reply_type        r;
      logic [GAP_W:0]   size;
      logic [GAP_W:0]   best_gap;
      logic [GAP_W:0]   best_pos;
      logic [GAP_W:0]   pos;
      int               best;
      int               free_slot;
      r.status  = ST_OK;
      r.offset  = '0;
      r.granted = '0;
      size = ({1'b0, bytes} + 26'd7) & ~26'd7;
      if (size == 0 || size > (GAP_W+1)'(MAX_SLICE_BYTES)) begin
         r.status = ST_SIZE;
         return r;
      end
      best      = -2;
      free_slot = -1;
      best_gap  = '0;
      best_pos  = '0;
      if ({1'b0, root_free} >= size) begin
         best     = -1;
         best_gap = {1'b0, root_free};
      end
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (!slot_used[i]) begin
            if (free_slot < 0) free_slot = i;
            continue;
         end
         pos = (GAP_W+1)'(slot_start[i]) + (GAP_W+1)'(slot_len[i]);
         if ({1'b0, slot_gap[i]} < size) continue;
         if (best == -2 || {1'b0, slot_gap[i]} < best_gap ||
             ({1'b0, slot_gap[i]} == best_gap && pos < best_pos)) begin
            best     = i;
            best_gap = {1'b0, slot_gap[i]};
            best_pos = pos;
         end
      end
      if (best == -2) begin
         r.status = ST_NOFIT;
         return r;
      end
      if (free_slot < 0) begin
         r.status = ST_FULL;
         return r;
      end
      if (best == -1) root_free = '0;
      else slot_gap[best] = '0;
      slot_used[free_slot]  = 1'b1;
      slot_start[free_slot] = best_pos[START_W-1:0];
      slot_len[free_slot]   = size[LEN_W-1:0];
      slot_gap[free_slot]   = GAP_W'(best_gap - size);
      r.offset  = best_pos[START_W-1:0];
      r.granted = size[LEN_W-1:0];
      return r;
   endfunction

   function automatic reply_type release_slice(input start_type offset);
      reply_type r;
      int        hit;
      int        pred;
      r.status  = ST_OK;
      r.offset  = '0;
      r.granted = '0;
      hit  = -1;
      pred = -1;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (slot_used[i] && slot_start[i] == offset) begin
            hit = i;
            break;
         end
      end
      if (hit < 0) begin
         r.status = ST_NOTALLOC;
         return r;
      end
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (!slot_used[i] || slot_start[i] >= offset) continue;
         if (pred < 0 || slot_start[i] > slot_start[pred]) pred = i;
      end
      if (pred < 0) root_free = root_free + GAP_W'(slot_len[hit]) + slot_gap[hit];
      else slot_gap[pred] = slot_gap[pred] + GAP_W'(slot_len[hit]) + slot_gap[hit];
      r.granted      = slot_len[hit];
      slot_used[hit] = 1'b0;
      return r;
   endfunction

   task automatic issue_request(input func_type func, input logic [REQ_W-1:0] bytes,
                                input start_type offset);
      reply_type reply;
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = '0;
      req_tdata[REQ_W-1:0]       = bytes;
      req_tdata[REQ_W +: START_W] = offset;
      do @(posedge clock); while (!req_tready);
      if (func == FUNC_ALLOC) reply = alloc_slice(bytes);
      else reply = release_slice(offset);
      pending_replies.push_back(reply);
   endtask

   task automatic wait_for_replies();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic release_all();
      start_type live[$];
      int        idx;
      start_type offset;
      foreach (slot_used[i]) if (slot_used[i]) live.push_back(slot_start[i]);
      while (live.size() != 0) begin
         idx    = $urandom_range(0, live.size() - 1);
         offset = live[idx];
         live.delete(idx);
         issue_request(FUNC_FREE, REQ_W'($urandom), offset);
      end
   endtask

   task automatic random_request(input int alloc_pct);
      start_type          live[$];
      int                 pick;
      logic [REQ_W-1:0]   bytes;
      start_type          offset;
      bytes  = REQ_W'($urandom);
      offset = START_W'($urandom);
      pick   = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct) begin
         if (pick < 50) bytes = REQ_W'($urandom_range(1, 2048));
         else if (pick < 75) bytes = REQ_W'($urandom_range(1, MAX_SLICE_BYTES));
         else if (pick < 85) bytes = REQ_W'(MAX_SLICE_BYTES - 8 + $urandom_range(0, 16));
         issue_request(FUNC_ALLOC, bytes, offset);
      end else begin
         foreach (slot_used[i]) if (slot_used[i]) live.push_back(slot_start[i]);
         if (live.size() != 0 && pick < 80)
            offset = live[$urandom_range(0, live.size() - 1)];
         else if (live.size() != 0 && pick < 90)
            offset = live[$urandom_range(0, live.size() - 1)] + start_type'(8);
         issue_request(FUNC_FREE, bytes, offset);
      end
   endtask

   task automatic test_unknown_free();
      issue_request(FUNC_FREE, '1, '0);
      issue_request(FUNC_FREE, REQ_W'($urandom), '1);
      issue_request(FUNC_FREE, '0, start_type'(8));
   endtask

   task automatic test_size_limits();
      issue_request(FUNC_ALLOC, '0, '0);
      issue_request(FUNC_ALLOC, REQ_W'(1), '1);
      issue_request(FUNC_ALLOC, REQ_W'(7), START_W'($urandom));
      issue_request(FUNC_ALLOC, REQ_W'(MAX_SLICE_BYTES - 7), START_W'($urandom));
      issue_request(FUNC_ALLOC, REQ_W'(MAX_SLICE_BYTES), START_W'($urandom));
      issue_request(FUNC_ALLOC, REQ_W'(MAX_SLICE_BYTES + 1), START_W'($urandom));
      issue_request(FUNC_ALLOC, '1, START_W'($urandom));
      issue_request(FUNC_ALLOC, 25'h1000000, START_W'($urandom));
      issue_request(FUNC_ALLOC, REQ_W'(8), START_W'($urandom));
   endtask

   task automatic test_release_merge();
      issue_request(FUNC_FREE, '1, '0);
      issue_request(FUNC_FREE, REQ_W'($urandom), start_type'(16));
      issue_request(FUNC_FREE, REQ_W'($urandom), start_type'(16 + 2 * MAX_SLICE_BYTES));
      issue_request(FUNC_FREE, REQ_W'($urandom), start_type'(16));
      release_all();
   endtask

   task automatic test_gap_ties();
      repeat (4) issue_request(FUNC_ALLOC, REQ_W'(8), START_W'($urandom));
      issue_request(FUNC_FREE, REQ_W'($urandom), start_type'(0));
      issue_request(FUNC_FREE, REQ_W'($urandom), start_type'(16));
      repeat (3) issue_request(FUNC_ALLOC, REQ_W'(8), START_W'($urandom));
      release_all();
   endtask

   task automatic test_table_full();
      repeat (48) issue_request(FUNC_ALLOC, REQ_W'($urandom_range(1, 8)), START_W'($urandom));
      repeat (15) issue_request(FUNC_ALLOC, REQ_W'(MAX_SLICE_BYTES), START_W'($urandom));
      issue_request(FUNC_ALLOC, REQ_W'(MAX_SLICE_BYTES - 384), START_W'($urandom));
      issue_request(FUNC_ALLOC, REQ_W'(8), START_W'($urandom));
      issue_request(FUNC_ALLOC, '0, START_W'($urandom));
      issue_request(FUNC_FREE, REQ_W'($urandom), start_type'(384));
      issue_request(FUNC_ALLOC, REQ_W'(8), START_W'($urandom));
      issue_request(FUNC_ALLOC, REQ_W'(8), START_W'($urandom));
      issue_request(FUNC_ALLOC, REQ_W'(MAX_SLICE_BYTES + 8), START_W'($urandom));
      wait_for_replies();
      release_all();
   endtask

   task automatic test_stall_backpressure();
      hold_request = 1'b1;
      repeat (24) random_request(60);
      wait_for_replies();
   endtask

   task automatic test_random_traffic(input int count);
      int bias;
      for (int i = 0; i < count; i++) begin
         case ((i / 100) % 3)
            0:       bias = 80;
            1:       bias = 50;
            default: bias = 25;
         endcase
         random_request(bias);
         if (i % 300 == 299) wait_for_replies();
      end
   endtask

   initial begin
      ready_mode_type mode;
      int             mode_left;
      int             hold_left;
      rsp_tready = 1'b0;
      mode       = READY_ALWAYS;
      mode_left  = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
               READY_ALWAYS: rsp_tready = 1'b1;
               READY_MOSTLY: rsp_tready = ($urandom_range(0, 9) < 7);
               READY_RARELY: rsp_tready = ($urandom_range(0, 9) < 3);
               default:      rsp_tready = ((mode_left % 16) < 10);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            error_count++;
            $display("%0t: unexpected reply, expected none, actual status %0d data %h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tuser !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
            end
            if (rsp_tdata[START_W-1:0] !== want.offset) begin
               error_count++;
               $display("%0t: alloc_offset expected %h actual %h",
                        $time, want.offset, rsp_tdata[START_W-1:0]);
            end
            if (rsp_tdata[START_W +: LEN_W] !== want.granted) begin
               error_count++;
               $display("%0t: granted_bytes expected %h actual %h",
                        $time, want.granted, rsp_tdata[START_W +: LEN_W]);
            end
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = FUNC_ALLOC;
      error_count  = 0;
      cycle_count  = 0;
      burst_left   = 0;
      hold_request = 1'b0;
      foreach (slot_used[i]) begin
         slot_used[i]  = 1'b0;
         slot_start[i] = '0;
         slot_len[i]   = '0;
         slot_gap[i]   = '0;
      end
      root_free = GAP_W'(POOL_BYTES);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_unknown_free();
      test_size_limits();
      test_release_merge();
      test_gap_ties();
      test_table_full();
      test_stall_backpressure();
      test_random_traffic(1000);

      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
